>>> hdl/wbps_pkg.sv
// Package: shared types, register indexes and helpers for the wildcard byte pattern search.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int PAT_W     = 64;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = CFG_IDX_W'(3);

    // Live search settings, pattern length already clamped to the usable range
    typedef struct packed {
        logic [BYTE_W-1:0] wild_byte;
        logic [LEN_W-1:0]  used_len;
        logic [PAT_W-1:0]  pattern_low;
        logic [PAT_W-1:0]  pattern_high;
    } t_cfg;

    // Pick pattern byte idx out of the two 64-bit pattern words
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_W-1:0] lo,
        input logic [PAT_W-1:0] hi,
        input logic [3:0]       idx
    );
        logic [PAT_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

>>> hdl/wbps_if.sv
// Interfaces: byte input channel, result channel and configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/wbps_cfg.sv
// Configuration registers and pattern length clamp.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cfg #(
    parameter int PATTERN_MAX_BYTES = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wbps_cfg_if.sink     i_cfg,
    output wbps_pkg::t_cfg o_cfg
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] r_wildcard;
    logic [LEN_W-1:0]  r_length;
    logic [PAT_W-1:0]  r_pat_low;
    logic [PAT_W-1:0]  r_pat_high;
    logic [LEN_W-1:0]  used_len;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wildcard <= '0;
            r_length   <= LEN_W'(1);
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WILDCARD:     r_wildcard <= i_cfg.data[BYTE_W-1:0];
                CFG_PATTERN_LEN:  r_length   <= i_cfg.data[LEN_W-1:0];
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg.data;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Treat zero as one, saturate at the window size
    always_comb begin
        if (r_length == '0) begin
            used_len = LEN_W'(1);
        end else if (r_length > LEN_W'(PATTERN_MAX_BYTES)) begin
            used_len = LEN_W'(PATTERN_MAX_BYTES);
        end else begin
            used_len = r_length;
        end
    end

    assign o_cfg = '{wild_byte: r_wildcard, used_len: used_len,
                     pattern_low: r_pat_low, pattern_high: r_pat_high};

endmodule

`default_nettype wire

>>> hdl/wbps_match.sv
// Parallel compare of every pattern lane against the byte window.
`timescale 1ns / 1ps
`default_nettype none

module wbps_match #(
    parameter int PATTERN_MAX_BYTES = 16
) (
    input  wire wbps_pkg::t_cfg i_cfg,
    input  wire logic [7:0] i_win [PATTERN_MAX_BYTES],
    output logic            o_hit
);
    import wbps_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_MAX_BYTES);

    logic [PATTERN_MAX_BYTES-1:0] lane_ok;

    // Pattern byte g lines up with the byte (used_len - 1 - g) steps back
    for (genvar g = 0; g < PATTERN_MAX_BYTES; g++) begin : g_lane
        logic [IDX_W-1:0]  age;
        logic [BYTE_W-1:0] pat;
        assign age = IDX_W'(i_cfg.used_len - LEN_W'(g + 1));
        assign pat = pattern_byte(i_cfg.pattern_low, i_cfg.pattern_high, 4'(g));
        assign lane_ok[g] = (LEN_W'(g) >= i_cfg.used_len)
                         || (pat == i_cfg.wild_byte)
                         || (i_win[age] == pat);
    end

    assign o_hit = &lane_ok;

endmodule

`default_nettype wire

>>> hdl/wildcard_byte_pattern_search.sv
// Top level: wildcard byte pattern search over a streamed region.
//
//  Channel | Dir | Payload                          | Notes
//  i_cfg   | in  | index[7:0], data[63:0]           | always ready; indexes 0..3 used
//  i_in    | in  | data_byte[7:0], region_end       | one byte per request
//  o_out   | out | found, match_offset[31:0]        | at most one request per region
//
// Each byte sits in the input register, where the full window is compared in parallel,
// and its result (if any) is registered in the output stage as the byte advances.
// A new byte is taken every cycle unless the output stalls; single compare stage.
// Reset is synchronous: window, byte counter and match flag clear, registers go to
// their defaults. A stalled output holds the input stage, even for a byte that owes
// no result; both registers keep flowing whenever the output is free or being drained.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search #(
    parameter int PATTERN_MAX_BYTES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wbps_cfg_if.sink  i_cfg,
    wbps_in_if.sink   i_in,
    wbps_out_if.source o_out
);
    import wbps_pkg::*;

    localparam int HIST = PATTERN_MAX_BYTES - 1;

    t_cfg cfg;

    // Input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Region state
    logic [BYTE_W-1:0]  r_hist [HIST];
    logic [COUNT_W-1:0] r_count;
    logic               r_done;

    // Output stage
    logic               r_out_valid;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_offset;

    logic [BYTE_W-1:0]  win [PATTERN_MAX_BYTES];
    logic               advance;
    logic               counted;
    logic [COUNT_W-1:0] n_count;
    logic               lanes_hit;
    logic               hit;
    logic               emit;
    logic [COUNT_W-1:0] n_offset;

    wbps_cfg #(.PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Window: slot 0 is the byte under test, slot k the byte k steps earlier
    always_comb begin
        win[0] = r_in_byte;
        for (int k = 1; k < PATTERN_MAX_BYTES; k++) begin
            win[k] = r_hist[k-1];
        end
    end

    wbps_match #(.PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)) u_match (
        .i_cfg (cfg),
        .i_win (win),
        .o_hit (lanes_hit)
    );

    // Advance the input stage when the output register is free or draining
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Saturating byte count; a saturated counter can no longer match
    assign counted  = (r_count != '1);
    assign n_count  = counted ? r_count + COUNT_W'(1) : r_count;
    assign hit      = !r_done && counted && (n_count >= COUNT_W'(cfg.used_len)) && lanes_hit;
    assign emit     = hit || (!r_done && r_in_last);
    assign n_offset = hit ? n_count - COUNT_W'(cfg.used_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.region_end;
        end
    end

    // Region state: clear on the last byte, freeze after a match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST; k++) begin
                r_hist[k] <= '0;
            end
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                for (int k = 0; k < HIST; k++) begin
                    r_hist[k] <= '0;
                end
                r_count <= '0;
                r_done  <= 1'b0;
            end else if (!r_done) begin
                for (int k = 0; k < HIST; k++) begin
                    r_hist[k] <= win[k];
                end
                r_count <= n_count;
                r_done  <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_found  <= hit;
            r_out_offset <= n_offset;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.match_offset = r_out_offset;

    // A not-found result always carries a zero offset
    a_miss_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_offset == '0)
        else $error("not-found result with nonzero offset");

    // The last byte of a region leaves a clean region state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_count == '0 && !r_done)
        else $error("region state not cleared after last byte");

    // A match mid-region sets the done flag
    a_hit_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && hit && !r_in_last |=> r_done)
        else $error("match did not set done flag");

    // A byte held by a stalled output stays in the input stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("stalled input stage lost its byte");

    // Results are only produced while a match is still open or at a region end
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |-> !r_done)
        else $error("result produced after a match in the same region");

endmodule

`default_nettype wire
